>>> design/lsr_pkg.sv
package lsr_pkg;

    // default stack depth and fixed field widths
    localparam int unsigned DEPTH_DEF = 128;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned ACT_W     = 2;
    localparam int unsigned STAT_W    = 2;
    localparam int unsigned CNT_OUT_W = 8;

    // word returned by pop or peek on an empty stack
    localparam logic [WORD_W-1:0] UNDERFLOW_WORD = '1;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH    = 2'd0,
        ACT_POP     = 2'd1,
        ACT_PEEK    = 2'd2,
        ACT_REVERSE = 2'd3
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic exec;
        logic rev_read;
        logic rev_wlo;
        logic rev_whi;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_action act;
        logic    rev_needed;
        logic    rev_last;
        logic    out_free;
    } t_stat;

endpackage

>>> design/lsr_if.sv
interface lsr_in_if;
    import lsr_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [ACT_W-1:0]          action;
    logic signed [WORD_W-1:0]  push_value;

    modport source (output valid, output action, output push_value, input ready);
    modport sink   (input valid, input action, input push_value, output ready);
endinterface

interface lsr_out_if;
    import lsr_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [WORD_W-1:0]  read_value;
    logic [STAT_W-1:0]         status;
    logic [CNT_OUT_W-1:0]      count;
    logic                      is_empty;
    logic                      is_full;

    modport source (output valid, output read_value, output status, output count,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input read_value, input status, input count,
                    input is_empty, input is_full, output ready);
    modport monitor (input valid, input ready, input read_value, input status,
                     input count, input is_empty, input is_full);
endinterface

>>> design/lifo_stack_with_reverse.sv
// Channel  Dir  Fields                                          Transfer
// i_in     in   action[1:0], push_value[31:0]                   valid & ready
// o_out    out  read_value[31:0], status[1:0], count[7:0],      valid & ready
//               is_empty, is_full
//
// Push, pop and peek go through accept, one memory access and load of the
// output register; a new item is accepted only after the last result is loaded.
// Reverse makes floor(count/2) swaps: one read of both ends and two
// single-port writes per swap, set by the single memory write port.
// Reset (synchronous, active low) empties the stack; memory is not cleared.
// A result still waiting at the output holds the next item in its last cycle.
module lifo_stack_with_reverse
    import lsr_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEF
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    lsr_in_if.sink     i_in,
    lsr_out_if.source  o_out
);

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    assign i_in.ready = in_ready;

    lsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lsr_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_action     (i_in.action),
        .i_push_value (i_in.push_value),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_out        (o_out)
    );

endmodule

>>> design/lsr_ctrl.sv
module lsr_ctrl
    import lsr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_OP   = 6'b000010,
        S_RRD  = 6'b000100,
        S_RWLO = 6'b001000,
        S_RWHI = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = S_OP;
                end
            end
            S_OP: begin
                o_cmd.exec = 1'b1;
                if (i_stat.act == ACT_REVERSE && i_stat.rev_needed) begin
                    n_state = S_RRD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RRD: begin
                o_cmd.rev_read = 1'b1;
                n_state = S_RWLO;
            end
            S_RWLO: begin
                o_cmd.rev_wlo = 1'b1;
                n_state = S_RWHI;
            end
            S_RWHI: begin
                o_cmd.rev_whi = 1'b1;
                n_state = i_stat.rev_last ? S_DONE : S_RRD;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> design/lsr_dp.sv
module lsr_dp
    import lsr_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEF
)
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [ACT_W-1:0]          i_action,
    input  logic signed [WORD_W-1:0]  i_push_value,
    input  t_cmd                      i_cmd,
    output t_stat                     o_stat,
    lsr_out_if.source                 o_out
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    // stack storage and its registered read ports
    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] r_rda;
    logic [WORD_W-1:0] r_rdb;

    // item and stack state
    t_action           r_act;
    logic [WORD_W-1:0] r_val;
    logic [CW-1:0]     r_cnt;
    logic [CW-1:0]     n_cnt;
    logic [AW-1:0]     r_lo;
    logic [AW-1:0]     n_lo;
    logic [AW-1:0]     r_hi;
    logic [AW-1:0]     n_hi;
    t_status           r_status;
    t_status           n_status;
    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;
    logic              r_from_mem;
    logic              n_from_mem;

    // output register
    logic                     r_out_valid;
    logic [WORD_W-1:0]        r_out_value;
    t_status                  r_out_status;
    logic [CNT_OUT_W-1:0]     r_out_count;
    logic                     r_out_empty;
    logic                     r_out_full;

    // memory port controls
    logic              we;
    logic [AW-1:0]     wa;
    logic [WORD_W-1:0] wd;
    logic              re;
    logic [AW-1:0]     raa;
    logic [AW-1:0]     rab;

    logic [CW-1:0]             cnt_m1;
    logic                      cnt_full;
    logic                      cnt_empty;
    logic [CW+CNT_OUT_W-1:0]   cnt_ext;
    logic [AW:0]               lo_p2;

    assign cnt_m1    = r_cnt - CW'(1);
    assign cnt_full  = (r_cnt == CW'(DEPTH));
    assign cnt_empty = (r_cnt == '0);
    assign cnt_ext   = {{CNT_OUT_W{1'b0}}, r_cnt};
    assign lo_p2     = {1'b0, r_lo} + (AW+1)'(2);

    assign o_stat.act        = r_act;
    assign o_stat.rev_needed = (r_cnt >= CW'(2));
    assign o_stat.rev_last   = (lo_p2 >= {1'b0, r_hi});
    assign o_stat.out_free   = !r_out_valid || o_out.ready;

    // execute actions and reverse swaps
    always_comb begin
        we         = 1'b0;
        wa         = r_lo;
        wd         = r_val;
        re         = 1'b0;
        raa        = r_lo;
        rab        = r_hi;
        n_cnt      = r_cnt;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_status   = r_status;
        n_word     = r_word;
        n_from_mem = r_from_mem;
        if (i_cmd.exec) begin
            n_status   = ST_OK;
            n_word     = '0;
            n_from_mem = 1'b0;
            case (r_act)
                ACT_PUSH: begin
                    if (cnt_full) begin
                        n_status = ST_OVERFLOW;
                    end else begin
                        we    = 1'b1;
                        wa    = r_cnt[AW-1:0];
                        n_cnt = r_cnt + CW'(1);
                    end
                end
                ACT_POP, ACT_PEEK: begin
                    if (cnt_empty) begin
                        n_status = ST_UNDERFLOW;
                        n_word   = UNDERFLOW_WORD;
                    end else begin
                        re         = 1'b1;
                        raa        = cnt_m1[AW-1:0];
                        n_from_mem = 1'b1;
                        if (r_act == ACT_POP) begin
                            n_cnt = cnt_m1;
                        end
                    end
                end
                ACT_REVERSE: begin
                    n_lo = '0;
                    n_hi = cnt_m1[AW-1:0];
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
        if (i_cmd.rev_read) begin
            re = 1'b1;
        end
        if (i_cmd.rev_wlo) begin
            we = 1'b1;
            wa = r_lo;
            wd = r_rdb;
        end
        if (i_cmd.rev_whi) begin
            we   = 1'b1;
            wa   = r_hi;
            wd   = r_rda;
            n_lo = r_lo + AW'(1);
            n_hi = r_hi - AW'(1);
        end
    end

    // memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (re) begin
            r_rda <= mem[raa];
            r_rdb <= mem[rab];
        end
    end

    // hold item and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_act <= t_action'(i_action);
            r_val <= i_push_value;
        end
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_status   <= n_status;
        r_word     <= n_word;
        r_from_mem <= n_from_mem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // output register: load on finish, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_value  <= r_from_mem ? r_rda : r_word;
            r_out_status <= r_status;
            r_out_count  <= cnt_ext[CNT_OUT_W-1:0];
            r_out_empty  <= cnt_empty;
            r_out_full   <= cnt_full;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.read_value = r_out_value;
    assign o_out.status     = r_out_status;
    assign o_out.count      = r_out_count;
    assign o_out.is_empty   = r_out_empty;
    assign o_out.is_full    = r_out_full;

endmodule

>>> design/lsr_chk.sv
module lsr_chk
    import lsr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic                      i_ready,
    input  logic signed [WORD_W-1:0]  i_read_value,
    input  logic [STAT_W-1:0]         i_status,
    input  logic [CNT_OUT_W-1:0]      i_count,
    input  logic                      i_is_empty,
    input  logic                      i_is_full
);

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_read_value)
            && $stable(i_status) && $stable(i_count))
        else $error("stalled result changed");

    // overflow only on a full stack
    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status == ST_OVERFLOW |-> i_is_full
            && i_read_value == '0)
        else $error("overflow without full stack");

    // underflow only on an empty stack, with the underflow word
    a_unf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status == ST_UNDERFLOW |-> i_is_empty
            && i_read_value == UNDERFLOW_WORD)
        else $error("underflow without empty stack");

    // empty and full never together, empty means zero count
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> !(i_is_empty && i_is_full)
            && (!i_is_empty || i_count == '0))
        else $error("inconsistent flags");

endmodule

bind lifo_stack_with_reverse lsr_chk u_lsr_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_out.valid),
    .i_ready      (o_out.ready),
    .i_read_value (o_out.read_value),
    .i_status     (o_out.status),
    .i_count      (o_out.count),
    .i_is_empty   (o_out.is_empty),
    .i_is_full    (o_out.is_full)
);
